FILE: rtl/sha1c_pkg.sv
// Package for the SHA-1 block compressor: constants, command codes and round functions.
`timescale 1ns / 1ps
package sha1c_pkg;

    localparam int WORD_W       = 32;
    localparam int DIGEST_WORDS = 5;
    localparam int SCHED_WORDS  = 16;
    localparam int ROUND_COUNT  = 80;
    localparam int ROUND_W      = 7;
    localparam int IDX_W        = 3;
    localparam int CMD_W        = 2;
    localparam int IN_DATA_W    = 40;
    localparam int OUT_DATA_W   = 40;

    typedef logic [WORD_W-1:0]  word_t;
    typedef logic [ROUND_W-1:0] round_t;
    typedef logic [CMD_W-1:0]   cmd_t;

    localparam cmd_t CMD_MSG     = 2'd0;
    localparam cmd_t CMD_LOAD    = 2'd1;
    localparam cmd_t CMD_RESTORE = 2'd2;

    localparam word_t H0_INIT = 32'h67452301;
    localparam word_t H1_INIT = 32'hEFCDAB89;
    localparam word_t H2_INIT = 32'h98BADCFE;
    localparam word_t H3_INIT = 32'h10325476;
    localparam word_t H4_INIT = 32'hC3D2E1F0;

    localparam word_t K0 = 32'h5A827999;
    localparam word_t K1 = 32'h6ED9EBA1;
    localparam word_t K2 = 32'h8F1BBCDC;
    localparam word_t K3 = 32'hCA62C1D6;

    localparam round_t ROUND_20   = 7'd20;
    localparam round_t ROUND_40   = 7'd40;
    localparam round_t ROUND_60   = 7'd60;
    localparam round_t ROUND_LAST = 7'd79;

    function automatic word_t init_word(input logic [IDX_W-1:0] idx);
        word_t w;
        case (idx)
            3'd0:    w = H0_INIT;
            3'd1:    w = H1_INIT;
            3'd2:    w = H2_INIT;
            3'd3:    w = H3_INIT;
            default: w = H4_INIT;
        endcase
        return w;
    endfunction

    // Choose, parity and majority, by quarter of the 80 rounds.
    function automatic word_t round_f(input round_t t, input word_t b, input word_t c,
                                      input word_t d);
        word_t f;
        if (t < ROUND_20)
            f = (b & c) | (~b & d);
        else if (t < ROUND_40)
            f = b ^ c ^ d;
        else if (t < ROUND_60)
            f = (b & c) | (b & d) | (c & d);
        else
            f = b ^ c ^ d;
        return f;
    endfunction

    function automatic word_t round_k(input round_t t);
        word_t k;
        if (t < ROUND_20)
            k = K0;
        else if (t < ROUND_40)
            k = K1;
        else if (t < ROUND_60)
            k = K2;
        else
            k = K3;
        return k;
    endfunction

endpackage

FILE: rtl/sha1_block_compress.sv
// SHA-1 block compressor: collects sixteen message words, runs 80 rounds, emits the digest.
// Items are taken only in the load state; the sixteenth message word starts a compression of
// 80 rounds (one shared round adder, one round a cycle), then the final add into the chain,
// then five digest items, one a cycle when the sink is ready; no item is taken meanwhile.
// Asynchronous active-low reset restores the standard initial chaining value and
// empties the word count; the schedule window holds no reset value.
`timescale 1ns / 1ps
module sha1_block_compress
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // s_tdata: data [31:0], chain_index [34:32], zero fill [39:35]
    input  logic [sha1c_pkg::IN_DATA_W-1:0]  s_tdata,
    // s_tuser: cmd [1:0]
    input  logic [sha1c_pkg::CMD_W-1:0]      s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // m_tdata: hash_word [31:0], word_index [34:32], zero fill [39:35]
    output logic [sha1c_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic                             m_tlast
);
    import sha1c_pkg::*;

    localparam logic [1:0] ST_LOAD  = 2'd0;
    localparam logic [1:0] ST_ROUND = 2'd1;
    localparam logic [1:0] ST_ADD   = 2'd2;
    localparam logic [1:0] ST_OUT   = 2'd3;

    localparam logic [3:0]       LAST_WORD = 4'd15;
    localparam logic [IDX_W-1:0] LAST_IDX  = 3'd4;

    logic [1:0]       state_reg, state_next;
    logic [3:0]       count_reg, count_next;
    round_t           round_reg, round_next;
    logic [IDX_W-1:0] oidx_reg,  oidx_next;
    word_t            chain_reg [DIGEST_WORDS];
    word_t            chain_next [DIGEST_WORDS];
    word_t            win_reg [SCHED_WORDS];
    word_t            win_next [SCHED_WORDS];
    word_t            a_reg, b_reg, c_reg, d_reg, e_reg;
    word_t            a_next, b_next, c_next, d_next, e_next;

    logic             s_acc;
    word_t            in_word;
    logic [IDX_W-1:0] in_idx;
    word_t            sched_new;
    word_t            round_sum;

    assign s_acc   = s_tvalid && s_tready;
    assign in_word = s_tdata[WORD_W-1:0];
    assign in_idx  = s_tdata[WORD_W+IDX_W-1:WORD_W];

    // The window holds W[t] .. W[t+15], oldest at entry 0.
    assign sched_new = {win_reg[0][WORD_W-2:0] ^ win_reg[2][WORD_W-2:0]
                        ^ win_reg[8][WORD_W-2:0] ^ win_reg[13][WORD_W-2:0],
                        win_reg[0][WORD_W-1] ^ win_reg[2][WORD_W-1]
                        ^ win_reg[8][WORD_W-1] ^ win_reg[13][WORD_W-1]};

    assign round_sum = {a_reg[WORD_W-6:0], a_reg[WORD_W-1:WORD_W-5]}
                       + round_f(round_reg, b_reg, c_reg, d_reg)
                       + e_reg + round_k(round_reg) + win_reg[0];

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        round_next = round_reg;
        oidx_next  = oidx_reg;
        chain_next = chain_reg;
        win_next   = win_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        c_next     = c_reg;
        d_next     = d_reg;
        e_next     = e_reg;

        case (state_reg)
            ST_LOAD:
            begin
                if (s_acc)
                begin
                    case (s_tuser)
                        CMD_MSG:
                        begin
                            for (int i = 0; i < SCHED_WORDS - 1; i++)
                                win_next[i] = win_reg[i+1];
                            win_next[SCHED_WORDS-1] = in_word;
                            count_next = count_reg + 4'd1;
                            if (count_reg == LAST_WORD)
                            begin
                                state_next = ST_ROUND;
                                round_next = '0;
                                a_next     = chain_reg[0];
                                b_next     = chain_reg[1];
                                c_next     = chain_reg[2];
                                d_next     = chain_reg[3];
                                e_next     = chain_reg[4];
                            end
                        end
                        CMD_LOAD:
                        begin
                            if (in_idx <= LAST_IDX)
                                chain_next[in_idx] = in_word;
                        end
                        CMD_RESTORE:
                        begin
                            for (int i = 0; i < DIGEST_WORDS; i++)
                                chain_next[i] = init_word(IDX_W'(i));
                        end
                        default:
                        begin
                            state_next = ST_LOAD;
                        end
                    endcase
                end
            end
            ST_ROUND:
            begin
                for (int i = 0; i < SCHED_WORDS - 1; i++)
                    win_next[i] = win_reg[i+1];
                win_next[SCHED_WORDS-1] = sched_new;
                a_next     = round_sum;
                b_next     = a_reg;
                c_next     = {b_reg[1:0], b_reg[WORD_W-1:2]};
                d_next     = c_reg;
                e_next     = d_reg;
                round_next = round_reg + 7'd1;
                if (round_reg == ROUND_LAST)
                    state_next = ST_ADD;
            end
            ST_ADD:
            begin
                chain_next[0] = chain_reg[0] + a_reg;
                chain_next[1] = chain_reg[1] + b_reg;
                chain_next[2] = chain_reg[2] + c_reg;
                chain_next[3] = chain_reg[3] + d_reg;
                chain_next[4] = chain_reg[4] + e_reg;
                oidx_next     = '0;
                state_next    = ST_OUT;
            end
            ST_OUT:
            begin
                if (m_tready)
                begin
                    if (oidx_reg == LAST_IDX)
                    begin
                        oidx_next  = '0;
                        state_next = ST_LOAD;
                    end
                    else
                        oidx_next = oidx_reg + 3'd1;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            round_reg <= '0;
            oidx_reg  <= '0;
            for (int i = 0; i < DIGEST_WORDS; i++)
                chain_reg[i] <= init_word(IDX_W'(i));
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            round_reg <= round_next;
            oidx_reg  <= oidx_next;
            chain_reg <= chain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        c_reg   <= c_next;
        d_reg   <= d_next;
        e_reg   <= e_next;
    end

    assign s_tready = (state_reg == ST_LOAD);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tlast  = m_tvalid && (oidx_reg == LAST_IDX);
    assign m_tdata  = {{(OUT_DATA_W - WORD_W - IDX_W){1'b0}}, oidx_reg, chain_reg[oidx_reg]};

`ifndef SYNTH
    assert property (@(posedge clk) disable iff (!rst_n) !(s_tready && m_tvalid))
        else $error("input and output sides active together");

    assert property (@(posedge clk) disable iff (!rst_n)
        (s_acc && s_tuser == CMD_MSG && count_reg == LAST_WORD) |=> (state_reg == ST_ROUND))
        else $error("sixteenth message word did not start the rounds");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND && round_reg == ROUND_LAST) |=> (state_reg == ST_ADD))
        else $error("final round not followed by the chaining add");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND) |-> (round_reg <= ROUND_LAST))
        else $error("round counter beyond the last round");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> (s_tready && count_reg == 4'd0))
        else $error("digest ended without returning to an empty block");
`endif

endmodule

FILE: dv/tb_top.sv
// Testbench for the SHA-1 block compressor: predicted digests checked against the output stream.
`timescale 1ns / 1ps
module tb_top;
    import sha1c_pkg::*;

    localparam cmd_t CMD_SPARE     = 2'd3;
    localparam int   IDLE_LIMIT    = 3000;
    localparam int   HOLD_CYCLES   = 400;
    localparam int   SETTLE_CYCLES = 200;
    localparam int   NOISE_PCT     = 8;

    typedef struct packed {
        word_t            hash_word;
        logic [IDX_W-1:0] word_index;
        logic             last;
    } digest_item_t;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // s_tdata: data [31:0], chain_index [34:32], zero fill [39:35]
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    // s_tuser: cmd [1:0]
    cmd_t                  s_tuser  = CMD_MSG;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // m_tdata: hash_word [31:0], word_index [34:32], zero fill [39:35]
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;

    // Predicted state of the compressor.
    word_t        chain_val [DIGEST_WORDS];
    word_t        msg_words [SCHED_WORDS];
    int unsigned  msg_count;
    digest_item_t digest_q [$];

    int unsigned src_idle_pct  = 0;
    int unsigned snk_stall_pct = 0;
    bit          sink_hold     = 1'b0;
    int unsigned mismatches    = 0;
    int unsigned items_sent    = 0;
    int unsigned digests_seen  = 0;
    int unsigned blocks_done   = 0;
    int unsigned quiet_cycles  = 0;

    sha1_block_compress DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #1 clk = ~clk;

    function automatic word_t rotl(word_t x, int unsigned n);
        return (x << n) | (x >> (WORD_W - n));
    endfunction

    function automatic void restore_chain();
        chain_val[0] = H0_INIT;
        chain_val[1] = H1_INIT;
        chain_val[2] = H2_INIT;
        chain_val[3] = H3_INIT;
        chain_val[4] = H4_INIT;
    endfunction

    function automatic void compress_block();
        word_t w [ROUND_COUNT];
        word_t a, b, c, d, e, f, k, t_sum;
        for (int t = 0; t < ROUND_COUNT; t++)
        begin
            if (t < SCHED_WORDS)
                w[t] = msg_words[t];
            else
                w[t] = rotl(w[t-3] ^ w[t-8] ^ w[t-14] ^ w[t-16], 1);
        end
        a = chain_val[0];
        b = chain_val[1];
        c = chain_val[2];
        d = chain_val[3];
        e = chain_val[4];
        for (int t = 0; t < ROUND_COUNT; t++)
        begin
            if (t < 20)
            begin
                f = (b & c) | (~b & d);
                k = K0;
            end
            else if (t < 40)
            begin
                f = b ^ c ^ d;
                k = K1;
            end
            else if (t < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = K2;
            end
            else
            begin
                f = b ^ c ^ d;
                k = K3;
            end
            t_sum = rotl(a, 5) + f + e + k + w[t];
            e = d;
            d = c;
            c = rotl(b, 30);
            b = a;
            a = t_sum;
        end
        chain_val[0] += a;
        chain_val[1] += b;
        chain_val[2] += c;
        chain_val[3] += d;
        chain_val[4] += e;
    endfunction

    function automatic void predict_item(cmd_t c, word_t d, logic [IDX_W-1:0] idx);
        case (c)
            CMD_LOAD:
            begin
                // An index past the last chaining word is ignored.
                if (idx < DIGEST_WORDS)
                    chain_val[idx] = d;
            end
            CMD_RESTORE:
                restore_chain();
            CMD_MSG:
            begin
                msg_words[msg_count] = d;
                msg_count = (msg_count + 1) % SCHED_WORDS;
                if (msg_count == 0)
                begin
                    compress_block();
                    blocks_done++;
                    for (int k = 0; k < DIGEST_WORDS; k++)
                        digest_q.push_back('{hash_word: chain_val[k],
                                             word_index: k[IDX_W-1:0],
                                             last: (k == DIGEST_WORDS - 1)});
                end
            end
            default:
                ;
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t ns: mismatch in %s: got %h, expected %h", $time, what, got, want);
        mismatches++;
    endtask

    // Each digest item is compared with the oldest prediction.
    always @(posedge clk)
    begin
        digest_item_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            digests_seen++;
            if (digest_q.size() == 0)
                report_mismatch("unexpected digest item", m_tdata[WORD_W-1:0], 32'd0);
            else
            begin
                want = digest_q.pop_front();
                if (m_tdata[WORD_W-1:0] !== want.hash_word)
                    report_mismatch("hash_word", m_tdata[WORD_W-1:0], want.hash_word);
                if (m_tdata[WORD_W +: IDX_W] !== want.word_index)
                    report_mismatch("word_index", 32'(m_tdata[WORD_W +: IDX_W]),
                                    32'(want.word_index));
                if (m_tlast !== want.last)
                    report_mismatch("tlast", 32'(m_tlast), 32'(want.last));
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
            m_tready <= !sink_hold && ($urandom_range(99) >= snk_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("Timeout: no item moved for %0d cycles", IDLE_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_item(cmd_t c, word_t d, logic [IDX_W-1:0] idx);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= c;
        s_tdata  <= {{(IN_DATA_W - WORD_W - IDX_W){1'b0}}, idx, d};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_item(c, d, idx);
        items_sent++;
    endtask

    task automatic sender_pause();
        @(negedge clk);
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (digest_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic hold_sink(int unsigned cycles);
        sink_hold = 1'b1;
        repeat (cycles) @(posedge clk);
        sink_hold = 1'b0;
    endtask

    function automatic word_t pick_word();
        word_t w;
        case ($urandom_range(7))
            0:       w = '0;
            1:       w = '1;
            2:       w = 32'h8000_0000;
            default: w = $urandom();
        endcase
        return w;
    endfunction

    task automatic send_noise();
        case ($urandom_range(2))
            0:       send_item(CMD_LOAD, pick_word(), IDX_W'($urandom_range(7)));
            1:       send_item(CMD_RESTORE, pick_word(), IDX_W'($urandom_range(7)));
            default: send_item(CMD_SPARE, pick_word(), IDX_W'($urandom_range(7)));
        endcase
    endtask

    // Sixteen message words with the odd chaining command or ignored item mixed in.
    task automatic send_random_block();
        for (int i = 0; i < SCHED_WORDS; i++)
        begin
            while ($urandom_range(99) < NOISE_PCT)
                send_noise();
            send_item(CMD_MSG, pick_word(), IDX_W'($urandom_range(7)));
        end
    endtask

    task automatic test_directed();
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        for (int i = 0; i < 8; i++)
            send_item(CMD_MSG, (i % 2 == 0) ? 32'h0000_0000 : 32'hFFFF_FFFF, i[IDX_W-1:0]);
        // Chaining loads in the middle of a block keep the collected words.
        send_item(CMD_LOAD, 32'h0000_0000, 3'd0);
        send_item(CMD_LOAD, 32'hFFFF_FFFF, 3'd1);
        send_item(CMD_LOAD, 32'h8000_0000, 3'd2);
        send_item(CMD_LOAD, 32'h7FFF_FFFF, 3'd3);
        send_item(CMD_LOAD, 32'h0000_0001, 3'd4);
        send_item(CMD_LOAD, 32'hFFFF_FFFF, 3'd5);
        send_item(CMD_LOAD, 32'hFFFF_FFFF, 3'd7);
        send_item(CMD_SPARE, 32'hFFFF_FFFF, 3'd7);
        for (int i = 0; i < 8; i++)
            send_item(CMD_MSG, (i % 2 == 0) ? 32'h8000_0000 : 32'h0000_0001, 3'd7);
        send_item(CMD_RESTORE, 32'h0000_0000, 3'd0);
        sender_pause();
        wait_drained();
    endtask

    task automatic test_backpressure();
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        fork
            hold_sink(HOLD_CYCLES);
            for (int i = 0; i < 24; i++)
                send_item(CMD_MSG, pick_word(), IDX_W'($urandom_range(7)));
        join
        sender_pause();
    endtask

    task automatic test_drain_pause();
        src_idle_pct  = 20;
        snk_stall_pct = 20;
        for (int i = 0; i < 8; i++)
            send_item(CMD_MSG, pick_word(), IDX_W'($urandom_range(7)));
        sender_pause();
        wait_drained();
        send_item(CMD_RESTORE, pick_word(), IDX_W'($urandom_range(7)));
        send_random_block();
        sender_pause();
    endtask

    task automatic test_random_phases();
        int unsigned src_mix [4] = '{0, 54, 0, 6};
        int unsigned snk_mix [4] = '{0, 0, 54, 6};
        for (int p = 0; p < 4; p++)
        begin
            src_idle_pct  = src_mix[p];
            snk_stall_pct = snk_mix[p];
            for (int b = 0; b < 3; b++)
                send_random_block();
        end
        sender_pause();
    endtask

    initial
    begin
        restore_chain();
        msg_count = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_backpressure();
        test_drain_pause();
        test_random_phases();

        wait_drained();
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (digest_q.size() != 0)
            report_mismatch("digest items never produced", 32'(digest_q.size()), 32'd0);

        $display("Sent %0d items over %0d compressed blocks; %0d digest words came back.",
                 items_sent, blocks_done, digests_seen);
        $display("Covered chaining loads and restores, ignored commands, sink hold-off and idle mixes.");
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
